### sv/bdc_pkg.sv
// ---------------------------------------------------------------------------
// bdc_pkg: shared types and constants for the baud divisor calculator
// Sequencer states, divider request struct and the divider code map.
// ---------------------------------------------------------------------------
package bdc_pkg;

  // Default limit of the increment and modulus fields
  localparam int unsigned BDC_FIELD_LIMIT = 65535;

  // Serial divider geometry
  localparam int unsigned DVD_W   = 64;  // dividend and quotient width
  localparam int unsigned DVS_W   = 36;  // divisor and remainder width
  localparam int unsigned DCNT_W  = 7;   // iteration counter, holds DVD_W

  // Constant divisor for the error bound
  localparam logic [DVS_W-1:0] PERCENT_DIV = DVS_W'(100);

  // Request to the serial divider
  typedef struct packed {
    logic start;  // load operands and begin
    logic wide;   // full 64-bit dividend, else the low 36 bits only
  } div_req_t;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GCD1,
    ST_NUM,
    ST_DEN,
    ST_CHECK,
    ST_SCALE_M,
    ST_SCALE_N,
    ST_SCALE_NUM,
    ST_SCALE_DEN,
    ST_DVR,
    ST_MODV,
    ST_GCD2,
    ST_TNUM,
    ST_TDEN,
    ST_MUL,
    ST_ACH,
    ST_BND,
    ST_DECIDE
  } bdc_state_e;

  // Reference divider to its 3-bit register code
  function automatic logic [2:0] bdc_div_code(input logic [2:0] divider);
    logic [2:0] code;
    unique case (divider)
      3'd1:    code = 3'h5;
      3'd2:    code = 3'h4;
      3'd3:    code = 3'h3;
      3'd4:    code = 3'h2;
      3'd5:    code = 3'h1;
      3'd6:    code = 3'h0;
      3'd7:    code = 3'h6;
      default: code = 3'h5;
    endcase
    return code;
  endfunction

endpackage

### sv/bdc_div.sv
// ---------------------------------------------------------------------------
// bdc_div: bit-serial restoring divider
// One quotient bit per cycle; a short dividend gives 36 quotient bits, a wide one 64.
// ---------------------------------------------------------------------------
module bdc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bdc_pkg::div_req_t           req_i,
  input  logic [bdc_pkg::DVD_W-1:0]   dividend_i,
  input  logic [bdc_pkg::DVS_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [bdc_pkg::DVD_W-1:0]   quotient_o,
  output logic [bdc_pkg::DVS_W-1:0]   remainder_o
);
  import bdc_pkg::*;

  logic [DCNT_W-1:0] cnt_q;
  logic              done_q;
  logic [DVD_W-1:0]  dvd_q;
  logic [DVD_W-1:0]  quo_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;

  logic [DVS_W:0]    shifted;
  logic              ge;
  logic [DVS_W:0]    diff;
  logic [DVS_W-1:0]  rem_d;

  // Trial subtract of one bit step
  always_comb begin
    shifted = {rem_q, dvd_q[DVD_W-1]};
    ge      = shifted >= {1'b0, dvs_q};
    diff    = shifted - {1'b0, dvs_q};
    rem_d   = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
  end

  // Iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= req_i.wide ? DCNT_W'(DVD_W) : DCNT_W'(DVS_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DCNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.wide ? dividend_i : (dividend_i << (DVD_W - DVS_W));
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

### sv/baud_divisor_calculator.sv
// ---------------------------------------------------------------------------
// baud_divisor_calculator: UART fractional baud setting calculator
// Reduces clock/(16*baud) by GCD, scales it into the register fields, picks
// the reference divider and checks the achieved rate against a 3 % bound.
// ---------------------------------------------------------------------------
// One request at a time. All divisions run on the shared bit-serial divider:
// there are short divisions and the one wide division, and the two GCD
// loops take one division per Euclid step. Zero baud or zero clock skips
// the divisions and goes straight to the decision. A result waits in
// the output register while the next request is taken.
module baud_divisor_calculator #(
  parameter int unsigned FIELD_LIMIT = bdc_pkg::BDC_FIELD_LIMIT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [27:0] wanted_baud_i,
  input  logic [31:0] source_clock_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        update_valid_o,
  output logic [2:0]  ref_div_code_o,
  output logic [15:0] increment_value_o,
  output logic [15:0] modulus_value_o
);
  import bdc_pkg::*;

  localparam logic [31:0] LIM  = 32'(FIELD_LIMIT);
  localparam logic [31:0] LIM7 = 32'(FIELD_LIMIT * 7);

  bdc_state_e state_q, state_d;
  logic       issued_q;
  logic       out_valid_q;
  logic [4:0] mul_cnt_q;

  logic [27:0] baud_q;
  logic [31:0] clk_q;
  logic        zero_q;
  logic [35:0] a_q, b_q, g_q;
  logic [31:0] num_q, den_q, mx_q, tnum_q;
  logic [35:0] tden_q;
  logic [2:0]  divider_q;
  logic [15:0] modv_q;
  logic [47:0] mcand_q;
  logic [15:0] mpl_q;
  logic [63:0] prod_q;
  logic [47:0] ach_q;
  logic [23:0] bnd_q;
  logic        upd_q;
  logic [2:0]  code_q;
  logic [15:0] inc_q, mod_q;

  div_req_t    div_req;
  logic [63:0] div_dvd;
  logic [35:0] div_dvs;
  logic        div_done;
  logic [63:0] div_quo;
  logic [35:0] div_rem;

  logic        in_acc, out_free, is_div;
  logic [31:0] q32, n_val;
  logic [47:0] diff;
  logic        pass;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign q32        = div_quo[31:0];
  assign n_val      = q32 + 32'd1;

  bdc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (div_req),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dvs),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_acc) begin
                      state_d = ((wanted_baud_i == '0) || (source_clock_i == '0)) ?
                                ST_DECIDE : ST_GCD1;
                    end
      ST_GCD1:      if (div_done && div_rem == '0) state_d = ST_NUM;
      ST_NUM:       if (div_done) state_d = ST_DEN;
      ST_DEN:       if (div_done) state_d = ST_CHECK;
      ST_CHECK:     state_d = (num_q > LIM7 || den_q > LIM) ? ST_SCALE_M : ST_DVR;
      ST_SCALE_M:   if (div_done) state_d = ST_SCALE_N;
      ST_SCALE_N:   if (div_done) state_d = ST_SCALE_NUM;
      ST_SCALE_NUM: if (div_done) state_d = ST_SCALE_DEN;
      ST_SCALE_DEN: if (div_done) state_d = ST_DVR;
      ST_DVR:       if (div_done) state_d = ST_MODV;
      ST_MODV:      if (div_done) state_d = ST_GCD2;
      ST_GCD2:      if (div_done && div_rem == '0) state_d = ST_TNUM;
      ST_TNUM:      if (div_done) state_d = ST_TDEN;
      ST_TDEN:      if (div_done) state_d = ST_MUL;
      ST_MUL:       if (mul_cnt_q == 5'd1) state_d = ST_ACH;
      ST_ACH:       if (div_done) state_d = ST_BND;
      ST_BND:       if (div_done) state_d = ST_DECIDE;
      ST_DECIDE:    if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Divider operands per state
  always_comb begin
    is_div  = 1'b1;
    div_dvd = '0;
    div_dvs = 36'd1;
    unique case (state_q)
      ST_GCD1, ST_GCD2: begin
        div_dvd = {28'b0, a_q};
        div_dvs = b_q;
      end
      ST_NUM, ST_TNUM: begin
        div_dvd = {32'b0, clk_q};
        div_dvs = g_q;
      end
      ST_DEN: begin
        div_dvd = {32'b0, baud_q, 4'b0};
        div_dvs = g_q;
      end
      ST_TDEN: begin
        div_dvd = {28'b0, num_q, 4'b0};
        div_dvs = g_q;
      end
      ST_SCALE_M: begin
        div_dvd = {32'b0, num_q - 32'd1};
        div_dvs = {4'b0, LIM7};
      end
      ST_SCALE_N: begin
        div_dvd = {32'b0, den_q - 32'd1};
        div_dvs = {4'b0, LIM};
      end
      ST_SCALE_NUM: begin
        div_dvd = {32'b0, num_q};
        div_dvs = {4'b0, mx_q};
      end
      ST_SCALE_DEN: begin
        div_dvd = {32'b0, den_q};
        div_dvs = {4'b0, mx_q};
      end
      ST_DVR: begin
        div_dvd = {32'b0, num_q - 32'd1};
        div_dvs = {4'b0, LIM};
      end
      ST_MODV: begin
        div_dvd = {32'b0, num_q};
        div_dvs = {33'b0, divider_q};
      end
      ST_ACH: begin
        div_dvd = prod_q;
        div_dvs = tden_q;
      end
      ST_BND: begin
        div_dvd = {36'b0, baud_q};
        div_dvs = PERCENT_DIV;
      end
      default: is_div = 1'b0;
    endcase
    div_req.start = is_div && !issued_q;
    div_req.wide  = (state_q == ST_ACH);
  end

  // Rate error check
  always_comb begin
    diff = (ach_q >= {20'b0, baud_q}) ? (ach_q - {20'b0, baud_q})
                                      : ({20'b0, baud_q} - ach_q);
    pass = !zero_q && (diff < {24'b0, bnd_q});
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      mul_cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (div_req.start) issued_q <= 1'b1;
      else if (div_done) issued_q <= 1'b0;
      if (state_q == ST_TDEN && div_done) mul_cnt_q <= 5'd16;
      else if (state_q == ST_MUL) mul_cnt_q <= mul_cnt_q - 5'd1;
      if (state_q == ST_DECIDE && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      baud_q <= wanted_baud_i;
      clk_q  <= source_clock_i;
      zero_q <= (wanted_baud_i == '0) || (source_clock_i == '0);
      a_q    <= {4'b0, source_clock_i};
      b_q    <= {4'b0, wanted_baud_i, 4'b0};
    end
    if (div_done) begin
      unique case (state_q)
        ST_GCD1, ST_GCD2: begin
          a_q <= b_q;
          b_q <= div_rem;
          if (div_rem == '0) g_q <= b_q;
        end
        ST_NUM:       num_q <= q32;
        ST_DEN:       den_q <= q32;
        ST_SCALE_M:   mx_q  <= n_val;
        ST_SCALE_N:   if (n_val > mx_q) mx_q <= n_val;
        ST_SCALE_NUM: num_q <= (q32 == '0) ? 32'd1 : q32;
        ST_SCALE_DEN: den_q <= (q32 == '0) ? 32'd1 : q32;
        ST_DVR:       divider_q <= div_quo[2:0] + 3'd1;
        ST_MODV: begin
          modv_q <= div_quo[15:0] - 16'd1;
          a_q    <= {4'b0, clk_q};
          b_q    <= {num_q, 4'b0};
        end
        ST_TNUM:      tnum_q <= q32;
        ST_TDEN: begin
          tden_q  <= div_quo[35:0];
          mcand_q <= {16'b0, tnum_q};
          mpl_q   <= den_q[15:0];
          prod_q  <= '0;
        end
        ST_ACH:       ach_q <= div_quo[47:0];
        ST_BND:       bnd_q <= {1'b0, div_quo[21:0], 1'b0} + {2'b0, div_quo[21:0]};
        default: ;
      endcase
    end
    // Shift-add multiply, one multiplier bit a cycle
    if (state_q == ST_MUL) begin
      if (mpl_q[0]) prod_q <= prod_q + {16'b0, mcand_q};
      mcand_q <= {mcand_q[46:0], 1'b0};
      mpl_q   <= {1'b0, mpl_q[15:1]};
    end
    // Result register
    if (state_q == ST_DECIDE && out_free) begin
      upd_q  <= pass;
      code_q <= pass ? bdc_div_code(divider_q) : 3'd0;
      inc_q  <= pass ? (den_q[15:0] - 16'd1) : 16'd0;
      mod_q  <= pass ? modv_q : 16'd0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign update_valid_o    = upd_q;
  assign ref_div_code_o    = code_q;
  assign increment_value_o = inc_q;
  assign modulus_value_o   = mod_q;

endmodule

### sv/bdc_checker.sv
// ---------------------------------------------------------------------------
// bdc_checker: port-level checks for the baud divisor calculator
// Watches the handshakes and the result fields; bound to the top level.
// ---------------------------------------------------------------------------
module bdc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [27:0] wanted_baud_i,
  input logic [31:0] source_clock_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        update_valid_o,
  input logic [2:0]  ref_div_code_o,
  input logic [15:0] increment_value_o,
  input logic [15:0] modulus_value_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  // A taken request makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while not busy afterwards");

  // A new result appears only as the block finishes a request
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $fell(in_stall_o))
    else $error("result without request completion");

  // Rejected settings report all fields as zero
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !update_valid_o |->
      ref_div_code_o == 3'd0 && increment_value_o == 16'd0 && modulus_value_o == 16'd0)
    else $error("rejected result carries settings");

endmodule

bind baud_divisor_calculator bdc_checker u_bdc_checker (.*);
